// File: rtl/signed_integer_to_base_digits_core_macros.svh
// assertion shorthands used by the checker file
`ifndef SIGNED_INTEGER_TO_BASE_DIGITS_CORE_MACROS_SVH
`define SIGNED_INTEGER_TO_BASE_DIGITS_CORE_MACROS_SVH

// consequent must hold in the same cycle as the trigger
`define SIBD_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the trigger
`define SIBD_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sibd_pkg.sv
package sibd_pkg;

    localparam int VALUE_W             = 32;
    localparam int SYMBOL_W            = 8;
    localparam int BASE_W              = 5;
    localparam int ALPHA_W             = 64;
    localparam int ALPHABET_SIZE       = 16;
    localparam int SYM_IDX_W           = $clog2(ALPHABET_SIZE);
    localparam int CFG_INDEX_W         = 2;
    localparam int DEFAULT_MAX_BASE    = 16;
    localparam int DEFAULT_DIGIT_SLOTS = 32;
    localparam int QUEUE_DEPTH         = 2;
    // quotient bits resolved per cycle by the digit divider
    localparam int DIV_STEP_BITS       = 8;
    localparam int DIV_STEPS           = VALUE_W / DIV_STEP_BITS;

    localparam logic [SYMBOL_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [SYMBOL_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] NUL_CHAR   = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_SIZE,
        CFG_ALPHA_LOW,
        CFG_ALPHA_HIGH
    } cfg_reg_t;

    typedef logic [2*ALPHA_W-1:0] alphabet_t;

    // classified work item handed from front to back
    typedef struct packed {
        logic               bad;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERR,
        BK_DIV,
        BK_SIGN,
        BK_PREP,
        BK_PLAY
    } back_state_t;

    function automatic logic [SYMBOL_W-1:0] symbol_at(
        input alphabet_t             alpha,
        input logic [SYM_IDX_W-1:0]  k
    );
        return alpha[k*SYMBOL_W +: SYMBOL_W];
    endfunction

endpackage

// File: rtl/signed_integer_to_base_digits_core.sv
// Converts each signed 32-bit value into its text in the configured radix, one character
// byte per output beat, most significant digit first, with a leading '-' for negative
// values; an invalid alphabet (base_size below 2 or above MAX_BASE, or a used symbol that
// is zero, '+', '-' or repeated) gives one beat with bad_base set, symbol 0 and last set.
// The front stage checks the alphabet and takes the magnitude on the cycle it accepts a
// value, and a two-entry queue feeds the back end, so new values are taken while the back
// end works. The back end's divider resolves 8 quotient bits per cycle for each digit,
// and the back end then replays the stored digits from a small RAM at one beat per
// cycle while the output is not stalled. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module signed_integer_to_base_digits_core import sibd_pkg::*; #(
    parameter int MAX_BASE    = DEFAULT_MAX_BASE,
    parameter int DIGIT_SLOTS = DEFAULT_DIGIT_SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // value input channel
    input  logic                       value_valid,
    output logic                       value_stall,
    input  logic signed [VALUE_W-1:0]  value,
    // character output channel
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [SYMBOL_W-1:0]        symbol,
    output logic                       last,
    output logic                       bad_base,
    // register write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ALPHA_W-1:0]         cfg_data
);

    logic [BASE_W-1:0]  base_size_reg, base_size_next;
    logic [ALPHA_W-1:0] alpha_low_reg, alpha_low_next;
    logic [ALPHA_W-1:0] alpha_high_reg, alpha_high_next;
    alphabet_t          alphabet;

    logic  q_push;
    item_t q_push_item;
    logic  q_full;
    logic  q_pop;
    item_t q_head;
    logic  q_valid;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_size_next  = base_size_reg;
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_SIZE:  base_size_next  = cfg_data[BASE_W-1:0];
                CFG_ALPHA_LOW:  alpha_low_next  = cfg_data;
                CFG_ALPHA_HIGH: alpha_high_next = cfg_data;
                default:        ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg  <= '0;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
        end
        else
        begin
            base_size_reg  <= base_size_next;
            alpha_low_reg  <= alpha_low_next;
            alpha_high_reg <= alpha_high_next;
        end
    end

    // symbol 0 sits in the lowest byte of the low word
    assign alphabet = {alpha_high_reg, alpha_low_reg};

    // front: accept, validate alphabet, take sign and magnitude
    sibd_front #(
        .MAX_BASE (MAX_BASE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .base_size   (base_size_reg),
        .alphabet    (alphabet),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    // short queue decoupling front from back
    sibd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .not_empty (q_valid)
    );

    // back: digit divider, digit stack, character replay
    sibd_back #(
        .MAX_BASE    (MAX_BASE),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_size    (base_size_reg),
        .alphabet     (alphabet),
        .q_valid      (q_valid),
        .q_item       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .last         (last),
        .bad_base     (bad_base)
    );

endmodule

// File: rtl/sibd_ram.sv
module sibd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sibd_front.sv
module sibd_front import sibd_pkg::*; #(
    parameter int MAX_BASE = DEFAULT_MAX_BASE
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       value_valid,
    output logic                       value_stall,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [BASE_W-1:0]          base_size,
    input  alphabet_t                  alphabet,
    input  logic                       q_full,
    output logic                       q_push,
    output item_t                      q_item
);

    logic               f_valid_reg, f_valid_next;
    item_t              f_item_reg, f_item_next;
    item_t              classified;
    logic               accept;
    logic               alpha_ok;
    logic [SYMBOL_W-1:0] chk_sym;
    logic [VALUE_W-1:0]  raw;

    // alphabet check over all used symbols
    always_comb
    begin
        alpha_ok = (base_size >= BASE_W'(2)) && (base_size <= BASE_W'(MAX_BASE));
        chk_sym  = NUL_CHAR;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            if (BASE_W'(i) < base_size)
            begin
                chk_sym = symbol_at(alphabet, SYM_IDX_W'(i));
                if (chk_sym == NUL_CHAR || chk_sym == PLUS_CHAR || chk_sym == MINUS_CHAR)
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < ALPHABET_SIZE; j++)
                begin
                    if (BASE_W'(j) < base_size
                        && chk_sym == symbol_at(alphabet, SYM_IDX_W'(j)))
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        raw            = value;
        classified.bad = ~alpha_ok;
        classified.neg = raw[VALUE_W-1];
        classified.mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    end

    assign value_stall = f_valid_reg & q_full;
    assign accept      = value_valid & ~value_stall;
    assign q_push      = f_valid_reg & ~q_full;
    assign q_item      = f_item_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
            f_item_next  = classified;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg <= f_item_next;
    end

endmodule

// File: rtl/sibd_fifo.sv
module sibd_fifo import sibd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t pop_data,
    output logic  not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sibd_back.sv
module sibd_back import sibd_pkg::*; #(
    parameter int MAX_BASE    = DEFAULT_MAX_BASE,
    parameter int DIGIT_SLOTS = DEFAULT_DIGIT_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BASE_W-1:0]   base_size,
    input  alphabet_t           alphabet,
    input  logic                q_valid,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [SYMBOL_W-1:0] symbol,
    output logic                last,
    output logic                bad_base
);

    localparam int DIGIT_W = $clog2(MAX_BASE);
    localparam int PTR_W   = $clog2(DIGIT_SLOTS);
    localparam int CNT_W   = $clog2(DIGIT_SLOTS + 1);
    localparam int STEP_W  = $clog2(DIV_STEPS);

    back_state_t         state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [BASE_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                result_valid_reg, result_valid_next;
    logic [SYMBOL_W-1:0] symbol_reg, symbol_next;
    logic                last_reg, last_next;
    logic                bad_reg, bad_next;

    logic [VALUE_W-1:0]  div_mag;
    logic [BASE_W-1:0]   div_rem;
    logic                out_free;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [PTR_W-1:0]    ram_rd_addr;
    logic [DIGIT_W-1:0]  ram_rd_data;

    sibd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_SLOTS)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cnt_reg[PTR_W-1:0]),
        .wr_data (div_rem[DIGIT_W-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // restoring division, a slice of quotient bits per cycle
    always_comb
    begin
        div_mag = mag_reg;
        div_rem = rem_reg;
        for (int s = 0; s < DIV_STEP_BITS; s++)
        begin
            div_rem = {div_rem[BASE_W-2:0], div_mag[VALUE_W-1]};
            div_mag = {div_mag[VALUE_W-2:0], 1'b0};
            if (div_rem >= base_size)
            begin
                div_rem    = div_rem - base_size;
                div_mag[0] = 1'b1;
            end
        end
    end

    assign out_free = ~result_valid_reg | ~result_stall;

    always_comb
    begin
        state_next        = state_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        cnt_next          = cnt_reg;
        ptr_next          = ptr_reg;
        result_valid_next = result_valid_reg & result_stall;
        symbol_next       = symbol_reg;
        last_next         = last_reg;
        bad_next          = bad_reg;
        q_pop             = 1'b0;
        ram_wr_en         = 1'b0;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = ptr_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    neg_next   = q_item.neg;
                    mag_next   = q_item.mag;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = q_item.bad ? BK_ERR : BK_DIV;
                end
            end
            BK_ERR:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    symbol_next       = NUL_CHAR;
                    last_next         = 1'b1;
                    bad_next          = 1'b1;
                    state_next        = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                mag_next  = div_mag;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    ram_wr_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    if (div_mag == '0)
                    begin
                        state_next = neg_reg ? BK_SIGN : BK_PREP;
                    end
                end
            end
            BK_SIGN:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    symbol_next       = MINUS_CHAR;
                    last_next         = 1'b0;
                    bad_next          = 1'b0;
                    state_next        = BK_PREP;
                end
            end
            BK_PREP:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = PTR_W'(cnt_reg - 1'b1);
                ptr_next    = PTR_W'(cnt_reg - 1'b1);
                state_next  = BK_PLAY;
            end
            BK_PLAY:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    symbol_next       = symbol_at(alphabet, SYM_IDX_W'(ram_rd_data));
                    last_next         = (ptr_reg == '0);
                    bad_next          = 1'b0;
                    if (ptr_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ptr_reg - 1'b1;
                        ptr_next    = ptr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        bad_reg    <= bad_next;
    end

    assign result_valid = result_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;
    assign bad_base     = bad_reg;

endmodule

// File: rtl/sibd_checker.sv
`include "signed_integer_to_base_digits_core_macros.svh"

module sibd_checker import sibd_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input logic [SYMBOL_W-1:0] symbol,
    input logic                last,
    input logic                bad_base
);

    // a stalled beat holds
    `SIBD_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(symbol) && $stable(last) && $stable(bad_base), "stalled output beat changed")

    // an error beat stands alone and carries no character
    `SIBD_ASSERT_SAME(a_err_beat, result_valid && bad_base, last && symbol == NUL_CHAR, "error beat not a lone zero beat")

    // a minus byte can only be the sign, never the end of a run
    `SIBD_ASSERT_SAME(a_sign_beat, result_valid && symbol == MINUS_CHAR, !last && !bad_base, "minus sign ended a run")

endmodule

bind signed_integer_to_base_digits_core sibd_checker u_sibd_checker (.*);
